// ===== rtl/sls_pkg.sv =====
package sls_pkg;

   localparam int DEPTH  = 64;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int WORD_W = 32;
   localparam int MODE_W = 3;
   localparam int POS_W  = 7;
   localparam int STAT_W = 2;

   localparam logic [MODE_W-1:0] MODE_INSERT    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_DEL_INDEX = 3'd1;
   localparam logic [MODE_W-1:0] MODE_DEL_MATCH = 3'd2;
   localparam logic [MODE_W-1:0] MODE_READ      = 3'd3;
   localparam logic [MODE_W-1:0] MODE_FIND      = 3'd4;

   localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STAT_W-1:0] STAT_BAD_INDEX = 2'd1;
   localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd2;
   localparam logic [STAT_W-1:0] STAT_FULL      = 2'd3;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_REMOVE
   } cell_op_type;

   // Broadcast command that moves entries along the row.
   typedef struct packed {
      cell_op_type               op;
      logic [IDX_W-1:0]          target;
      logic signed [WORD_W-1:0]  data;
   } cell_cmd_type;

   // Broadcast lookup: value to match, position to pick, current count.
   typedef struct packed {
      logic signed [WORD_W-1:0]  word;
      logic [POS_W-1:0]          pos;
      logic [CNT_W-1:0]          count;
   } probe_type;

endpackage

// ===== rtl/sls_req_if.sv =====
interface sls_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [sls_pkg::MODE_W-1:0]            mode;
   logic [sls_pkg::POS_W-1:0]             position;
   logic signed [sls_pkg::WORD_W-1:0]     data_word;

   modport source (output valid, output mode, output position, output data_word,
                   input ready);
   modport sink (input valid, input mode, input position, input data_word,
                 output ready);
endinterface

// ===== rtl/sls_rsp_if.sv =====
interface sls_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [sls_pkg::STAT_W-1:0]            status;
   logic signed [sls_pkg::WORD_W-1:0]     found_word;
   logic [sls_pkg::IDX_W-1:0]             found_position;
   logic [sls_pkg::CNT_W-1:0]             entry_count;

   modport source (output valid, output status, output found_word,
                   output found_position, output entry_count, input ready);
   modport sink (input valid, input status, input found_word,
                 input found_position, input entry_count, output ready);
endinterface

// ===== rtl/sls_cell.sv =====
module sls_cell (
   input  logic                               clock,
   input  logic [sls_pkg::IDX_W-1:0]          index,
   input  sls_pkg::cell_cmd_type              cmd,
   input  sls_pkg::probe_type                 probe,
   input  logic signed [sls_pkg::WORD_W-1:0]  left_word,
   input  logic signed [sls_pkg::WORD_W-1:0]  right_word,
   output logic signed [sls_pkg::WORD_W-1:0]  word,
   output logic                               match,
   output logic signed [sls_pkg::WORD_W-1:0]  pick_word
);

   logic signed [sls_pkg::WORD_W-1:0] word_ff;
   logic signed [sls_pkg::WORD_W-1:0] word_in;
   logic                              live;

   // An entry only counts while it sits below the fill count.
   assign live = {1'b0, index} < probe.count;

   always_comb begin
      word_in = word_ff;
      case (cmd.op)
         sls_pkg::CELL_INSERT: begin
            if (index == cmd.target) begin
               word_in = cmd.data;
            end else if (index > cmd.target) begin
               word_in = left_word;
            end
         end
         sls_pkg::CELL_REMOVE: begin
            if (index >= cmd.target) begin
               word_in = right_word;
            end
         end
         default: word_in = word_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word      = word_ff;
   assign match     = live && (word_ff == probe.word);
   assign pick_word = ({1'b0, index} == probe.pos) ? word_ff : '0;

endmodule

// ===== rtl/sls_chain.sv =====
module sls_chain (
   input  logic                               clock,
   input  sls_pkg::cell_cmd_type              cmd,
   input  sls_pkg::probe_type                 probe,
   output logic [sls_pkg::DEPTH-1:0]          match_vec,
   output logic signed [sls_pkg::WORD_W-1:0]  pick_word
);

   logic signed [sls_pkg::WORD_W-1:0] words [sls_pkg::DEPTH];
   logic signed [sls_pkg::WORD_W-1:0] picks [sls_pkg::DEPTH];

   for (genvar g = 0; g < sls_pkg::DEPTH; g++) begin : g_cell
      logic signed [sls_pkg::WORD_W-1:0] left_word;
      logic signed [sls_pkg::WORD_W-1:0] right_word;

      // The first cell never takes from the left and the last one never
      // receives a live word from the right.
      if (g == 0) begin : g_first
         assign left_word = cmd.data;
      end else begin : g_left
         assign left_word = words[g-1];
      end
      if (g == sls_pkg::DEPTH - 1) begin : g_last
         assign right_word = '0;
      end else begin : g_right
         assign right_word = words[g+1];
      end

      sls_cell u_cell (
         .clock      (clock),
         .index      (sls_pkg::IDX_W'(g)),
         .cmd        (cmd),
         .probe      (probe),
         .left_word  (left_word),
         .right_word (right_word),
         .word       (words[g]),
         .match      (match_vec[g]),
         .pick_word  (picks[g])
      );
   end

   // At most one cell drives a nonzero pick, so an OR gathers it.
   always_comb begin
      pick_word = '0;
      for (int i = 0; i < sls_pkg::DEPTH; i++) begin
         pick_word = pick_word | picks[i];
      end
   end

endmodule

// ===== rtl/shifting_list_store.sv =====
// Ordered list store built as a row of shifting cells.
// Each request passes capture, cell scan and execute-and-shift in turn; its result
// is registered. A request is taken only in idle; execute stalls on a held result.
// The result register lets the next request be accepted while a result waits.
// Reset clears the fill count and the handshake state; entry storage is not cleared.
module shifting_list_store (
   input  logic       clock,
   input  logic       reset,
   sls_req_if.sink    req_bus,
   sls_rsp_if.source  rsp_bus
);

   // The sequencer walks every request through three steps. In the capture
   // step the request fields are latched. In the scan step every cell compares
   // its entry against the latched word and offers its entry if its position
   // matches; the match vector and picked word are registered. In the execute
   // step the highest match is encoded, the status is decided, and a single
   // shift command is broadcast to the row so all cells move at once.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EXEC
   } state_type;

   state_type                          state_ff;
   logic [sls_pkg::MODE_W-1:0]         mode_ff;
   logic [sls_pkg::POS_W-1:0]          pos_ff;
   logic signed [sls_pkg::WORD_W-1:0]  word_ff;
   logic [sls_pkg::CNT_W-1:0]          count_ff;
   logic [sls_pkg::DEPTH-1:0]          match_ff;
   logic signed [sls_pkg::WORD_W-1:0]  pick_ff;

   logic                               rsp_valid_ff;
   logic [sls_pkg::STAT_W-1:0]         rsp_status_ff;
   logic signed [sls_pkg::WORD_W-1:0]  rsp_word_ff;
   logic [sls_pkg::IDX_W-1:0]          rsp_pos_ff;

   sls_pkg::cell_cmd_type              cmd;
   sls_pkg::probe_type                 probe;
   logic [sls_pkg::DEPTH-1:0]          match_vec;
   logic signed [sls_pkg::WORD_W-1:0]  pick_word;

   logic                               hit_valid;
   logic [sls_pkg::IDX_W-1:0]          hit_pos;
   logic                               rsp_free;
   logic                               exec_fire;

   logic [sls_pkg::STAT_W-1:0]         status_in;
   logic signed [sls_pkg::WORD_W-1:0]  res_word_in;
   logic [sls_pkg::IDX_W-1:0]          res_pos_in;
   logic [sls_pkg::CNT_W-1:0]          count_in;
   sls_pkg::cell_op_type               op_in;
   logic [sls_pkg::IDX_W-1:0]          target_in;

   // The result register is free when empty or being taken this cycle.
   assign rsp_free  = !rsp_valid_ff || rsp_bus.ready;
   assign exec_fire = (state_ff == ST_EXEC) && rsp_free;

   assign req_bus.ready = (state_ff == ST_IDLE);

   // Highest set match bit wins, so later positions override earlier ones.
   always_comb begin
      hit_pos = '0;
      for (int i = 0; i < sls_pkg::DEPTH; i++) begin
         if (match_ff[i]) begin
            hit_pos = sls_pkg::IDX_W'(i);
         end
      end
   end
   assign hit_valid = |match_ff;

   // Decision for the request held in the execute step. Every rejected
   // request leaves the list untouched and reports zeros for word and position.
   always_comb begin
      status_in   = sls_pkg::STAT_OK;
      res_word_in = '0;
      res_pos_in  = '0;
      count_in    = count_ff;
      op_in       = sls_pkg::CELL_HOLD;
      target_in   = pos_ff[sls_pkg::IDX_W-1:0];
      case (mode_ff)
         sls_pkg::MODE_INSERT: begin
            // A position past the end is checked before a full list.
            if (pos_ff > sls_pkg::POS_W'(count_ff)) begin
               status_in = sls_pkg::STAT_BAD_INDEX;
            end else if (count_ff == sls_pkg::CNT_W'(sls_pkg::DEPTH)) begin
               status_in = sls_pkg::STAT_FULL;
            end else begin
               op_in       = sls_pkg::CELL_INSERT;
               res_word_in = word_ff;
               res_pos_in  = pos_ff[sls_pkg::IDX_W-1:0];
               count_in    = count_ff + sls_pkg::CNT_W'(1);
            end
         end
         sls_pkg::MODE_DEL_INDEX: begin
            if (pos_ff >= sls_pkg::POS_W'(count_ff)) begin
               status_in = sls_pkg::STAT_BAD_INDEX;
            end else begin
               op_in       = sls_pkg::CELL_REMOVE;
               res_word_in = pick_ff;
               res_pos_in  = pos_ff[sls_pkg::IDX_W-1:0];
               count_in    = count_ff - sls_pkg::CNT_W'(1);
            end
         end
         sls_pkg::MODE_DEL_MATCH: begin
            if (!hit_valid) begin
               status_in = sls_pkg::STAT_NOT_FOUND;
            end else begin
               // A matching entry equals the searched word by definition.
               op_in       = sls_pkg::CELL_REMOVE;
               target_in   = hit_pos;
               res_word_in = word_ff;
               res_pos_in  = hit_pos;
               count_in    = count_ff - sls_pkg::CNT_W'(1);
            end
         end
         sls_pkg::MODE_READ: begin
            if (pos_ff >= sls_pkg::POS_W'(count_ff)) begin
               status_in = sls_pkg::STAT_BAD_INDEX;
            end else begin
               res_word_in = pick_ff;
               res_pos_in  = pos_ff[sls_pkg::IDX_W-1:0];
            end
         end
         sls_pkg::MODE_FIND: begin
            if (!hit_valid) begin
               status_in = sls_pkg::STAT_NOT_FOUND;
            end else begin
               res_word_in = word_ff;
               res_pos_in  = hit_pos;
            end
         end
         default: status_in = sls_pkg::STAT_BAD_INDEX;
      endcase
   end

   // The row only moves in the cycle that the execute step completes.
   always_comb begin
      cmd.op     = exec_fire ? op_in : sls_pkg::CELL_HOLD;
      cmd.target = target_in;
      cmd.data   = word_ff;
      probe.word  = word_ff;
      probe.pos   = pos_ff;
      probe.count = count_ff;
   end

   sls_chain u_chain (
      .clock     (clock),
      .cmd       (cmd),
      .probe     (probe),
      .match_vec (match_vec),
      .pick_word (pick_word)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // A result taken in the same cycle that the next one is loaded stays valid.
         if (rsp_valid_ff && rsp_bus.ready && !exec_fire) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_bus.valid) begin
                  mode_ff  <= req_bus.mode;
                  pos_ff   <= req_bus.position;
                  word_ff  <= req_bus.data_word;
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               match_ff <= match_vec;
               pick_ff  <= pick_word;
               state_ff <= ST_EXEC;
            end
            ST_EXEC: begin
               if (rsp_free) begin
                  count_ff      <= count_in;
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= status_in;
                  rsp_word_ff   <= res_word_in;
                  rsp_pos_ff    <= res_pos_in;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.status         = rsp_status_ff;
   assign rsp_bus.found_word     = rsp_word_ff;
   assign rsp_bus.found_position = rsp_pos_ff;
   assign rsp_bus.entry_count    = count_ff;

`ifndef SYNTHESIS
   // The fill count can never pass the number of cells.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= sls_pkg::CNT_W'(sls_pkg::DEPTH))
      else $error("entry count exceeds list depth");

   // The count only moves when a request completes its execute step.
   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !exec_fire |=> $stable(count_ff))
      else $error("entry count changed outside the execute step");

   // A rejected request reports zero for word and position.
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != sls_pkg::STAT_OK) |->
      (rsp_word_ff == '0 && rsp_pos_ff == '0))
      else $error("rejected request carries a nonzero result");

   // An accepted request always reaches the scan step next.
   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> (state_ff == ST_SCAN))
      else $error("accepted request did not enter the scan step");
`endif

endmodule
